// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files of the hsv to rgb converter
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// delayed implication; the delay is given by the dly argument
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== hw/rtl/hsv2rgb_pkg.sv =====
// types and constants of the hsv to rgb converter
// no dependencies; used by every module of the block
package hsv2rgb_pkg;

    // input word: one pixel in hsv
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
    } t_hsv_word;

    // output word: one pixel in rgb
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       range_error;
    } t_rgb_word;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SECTOR_RED_YEL,
        SECTOR_YEL_GRN,
        SECTOR_GRN_CYN,
        SECTOR_CYN_BLU,
        SECTOR_BLU_MAG,
        SECTOR_MAG_RED
    } t_sector;

    // limits of valid inputs
    localparam logic [8:0] HUE_MAX = 9'd360;
    localparam logic [6:0] PCT_MAX = 7'd100;

    // hue sector boundaries in degrees
    localparam logic [8:0] HUE_60  = 9'd60;
    localparam logic [8:0] HUE_120 = 9'd120;
    localparam logic [8:0] HUE_180 = 9'd180;
    localparam logic [8:0] HUE_240 = 9'd240;
    localparam logic [8:0] HUE_300 = 9'd300;

    // width of the 1/600000 fixed-point quantities (max 600000)
    localparam int FX_W = 20;

    // chroma = s*v*60, offset = v*6000 - chroma
    localparam logic [FX_W-1:0] CHROMA_MUL = FX_W'(60);
    localparam logic [FX_W-1:0] OFFSET_MUL = FX_W'(6000);

    // floor(n*255/600000) = (n * SCALE_MUL) >> SCALE_SHIFT, exact for n <= 600000
    localparam int               SCALE_SHIFT = 40;
    localparam int               SCALE_MUL_W = 29;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 29'd467292447;
    localparam int               PROD_W = FX_W + SCALE_MUL_W;

    // stage 1 to stage 2
    typedef struct packed {
        logic [13:0] sv;
        logic [5:0]  x_weight;
        t_sector     sector;
        logic [6:0]  brightness;
        logic        range_error;
    } t_prep;

    // stage 3 to stage 4
    typedef struct packed {
        logic [FX_W-1:0] red_sum;
        logic [FX_W-1:0] green_sum;
        logic [FX_W-1:0] blue_sum;
        logic            range_error;
    } t_sum;

endpackage

// ===== hw/rtl/hsv2rgb_prep.sv =====
// stage 1: range check, hue sector, secondary weight and s*v product
// depends on hsv2rgb_pkg
module hsv2rgb_prep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  hsv2rgb_pkg::t_hsv_word i_word,
    output logic                   o_valid,
    output hsv2rgb_pkg::t_prep     o_prep
);

    logic                 r_valid;
    hsv2rgb_pkg::t_prep   r_prep;
    hsv2rgb_pkg::t_prep   n_prep;
    logic [8:0]           w_hue_off;
    logic [6:0]           w_hue_in;

    // range check, sector pick and hue offset within a 120-degree pair
    always_comb begin
        n_prep.range_error = (i_word.hue > hsv2rgb_pkg::HUE_MAX)
                          || (i_word.saturation > hsv2rgb_pkg::PCT_MAX)
                          || (i_word.brightness > hsv2rgb_pkg::PCT_MAX);
        priority if (i_word.hue < hsv2rgb_pkg::HUE_60) begin
            n_prep.sector = hsv2rgb_pkg::SECTOR_RED_YEL;
            w_hue_off     = i_word.hue;
        end else if (i_word.hue < hsv2rgb_pkg::HUE_120) begin
            n_prep.sector = hsv2rgb_pkg::SECTOR_YEL_GRN;
            w_hue_off     = i_word.hue;
        end else if (i_word.hue < hsv2rgb_pkg::HUE_180) begin
            n_prep.sector = hsv2rgb_pkg::SECTOR_GRN_CYN;
            w_hue_off     = i_word.hue - hsv2rgb_pkg::HUE_120;
        end else if (i_word.hue < hsv2rgb_pkg::HUE_240) begin
            n_prep.sector = hsv2rgb_pkg::SECTOR_CYN_BLU;
            w_hue_off     = i_word.hue - hsv2rgb_pkg::HUE_120;
        end else if (i_word.hue < hsv2rgb_pkg::HUE_300) begin
            n_prep.sector = hsv2rgb_pkg::SECTOR_BLU_MAG;
            w_hue_off     = i_word.hue - hsv2rgb_pkg::HUE_240;
        end else begin
            n_prep.sector = hsv2rgb_pkg::SECTOR_MAG_RED;
            w_hue_off     = i_word.hue - hsv2rgb_pkg::HUE_240;
        end
        w_hue_in = w_hue_off[6:0];
        // weight of x: 60 - |t - 60|, a triangle over the pair
        if (w_hue_in < hsv2rgb_pkg::HUE_60[6:0]) begin
            n_prep.x_weight = w_hue_in[5:0];
        end else begin
            n_prep.x_weight = 6'(hsv2rgb_pkg::HUE_120[6:0] - w_hue_in);
        end
        n_prep.sv         = 14'(i_word.saturation) * 14'(i_word.brightness);
        n_prep.brightness = i_word.brightness;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;

endmodule

// ===== hw/rtl/hsv2rgb_comp.sv =====
// stages 2 and 3: chroma, secondary and offset, then sector routing and sums
// depends on hsv2rgb_pkg
module hsv2rgb_comp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hsv2rgb_pkg::t_prep i_prep,
    output logic               o_valid,
    output hsv2rgb_pkg::t_sum  o_sum
);

    localparam int W = hsv2rgb_pkg::FX_W;

    logic                  r_valid2;
    logic                  r_valid3;
    logic [W-1:0]          r_cn;
    logic [W-1:0]          r_xn;
    logic [W-1:0]          r_mn;
    hsv2rgb_pkg::t_sector  r_sector;
    logic                  r_err2;
    logic [W-1:0]          n_cn;
    logic [W-1:0]          n_xn;
    logic [W-1:0]          n_mn;
    logic [W-1:0]          w_red;
    logic [W-1:0]          w_green;
    logic [W-1:0]          w_blue;
    hsv2rgb_pkg::t_sum     r_sum;
    hsv2rgb_pkg::t_sum     n_sum;

    // chroma, secondary and offset in units of 1/600000
    always_comb begin
        n_cn = W'(i_prep.sv) * hsv2rgb_pkg::CHROMA_MUL;
        n_xn = W'(i_prep.sv) * W'(i_prep.x_weight);
        n_mn = W'(i_prep.brightness) * hsv2rgb_pkg::OFFSET_MUL - n_cn;
    end

    // route chroma and secondary by sector, add offset
    always_comb begin
        unique case (r_sector)
            hsv2rgb_pkg::SECTOR_RED_YEL: begin
                w_red = r_cn; w_green = r_xn; w_blue = '0;
            end
            hsv2rgb_pkg::SECTOR_YEL_GRN: begin
                w_red = r_xn; w_green = r_cn; w_blue = '0;
            end
            hsv2rgb_pkg::SECTOR_GRN_CYN: begin
                w_red = '0;   w_green = r_cn; w_blue = r_xn;
            end
            hsv2rgb_pkg::SECTOR_CYN_BLU: begin
                w_red = '0;   w_green = r_xn; w_blue = r_cn;
            end
            hsv2rgb_pkg::SECTOR_BLU_MAG: begin
                w_red = r_xn; w_green = '0;   w_blue = r_cn;
            end
            default: begin
                w_red = r_cn; w_green = '0;   w_blue = r_xn;
            end
        endcase
        n_sum.red_sum     = w_red + r_mn;
        n_sum.green_sum   = w_green + r_mn;
        n_sum.blue_sum    = w_blue + r_mn;
        n_sum.range_error = r_err2;
    end

    // valid bits of stages 2 and 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cn     <= n_cn;
        r_xn     <= n_xn;
        r_mn     <= n_mn;
        r_sector <= i_prep.sector;
        r_err2   <= i_prep.range_error;
        r_sum    <= n_sum;
    end

    assign o_valid = r_valid3;
    assign o_sum   = r_sum;

endmodule

// ===== hw/rtl/hsv2rgb_scale.sv =====
// stage 4: scale each channel sum by 255/600000 with truncation, output register
// depends on hsv2rgb_pkg
module hsv2rgb_scale (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  hsv2rgb_pkg::t_sum      i_sum,
    output logic                   o_valid,
    output hsv2rgb_pkg::t_rgb_word o_word
);

    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int SH = hsv2rgb_pkg::SCALE_SHIFT;

    logic [PW-1:0]          w_prod_r;
    logic [PW-1:0]          w_prod_g;
    logic [PW-1:0]          w_prod_b;
    logic                   r_valid;
    hsv2rgb_pkg::t_rgb_word r_word;
    hsv2rgb_pkg::t_rgb_word n_word;

    // reciprocal multiply, the quotient is the byte above the shift; a range error gives zero colour
    always_comb begin
        w_prod_r = PW'(i_sum.red_sum)   * PW'(hsv2rgb_pkg::SCALE_MUL);
        w_prod_g = PW'(i_sum.green_sum) * PW'(hsv2rgb_pkg::SCALE_MUL);
        w_prod_b = PW'(i_sum.blue_sum)  * PW'(hsv2rgb_pkg::SCALE_MUL);
        n_word.range_error = i_sum.range_error;
        if (i_sum.range_error) begin
            n_word.red   = '0;
            n_word.green = '0;
            n_word.blue  = '0;
        end else begin
            n_word.red   = w_prod_r[SH +: 8];
            n_word.green = w_prod_g[SH +: 8];
            n_word.blue  = w_prod_b[SH +: 8];
        end
    end

    // output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// hsv to rgb converter: each accepted word passes through every register stage in order to o_rgb
// throughput one pixel per clock; four register stages (prep, products, sums, scale)
// busy is always low: the pipeline never stalls, and each result shows for one cycle
// synchronous active-low reset clears the valid bits; words in flight are dropped
// depends on hsv2rgb_pkg, hsv2rgb_prep, hsv2rgb_comp, hsv2rgb_scale, assert_macros.svh
`include "assert_macros.svh"

module hsv_to_rgb_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hsv2rgb_pkg::t_hsv_word i_hsv,
    output logic                   o_valid,
    output hsv2rgb_pkg::t_rgb_word o_rgb
);

    logic               w_accept;
    logic               w_prep_valid;
    hsv2rgb_pkg::t_prep w_prep;
    logic               w_sum_valid;
    hsv2rgb_pkg::t_sum  w_sum;

    // the pipeline takes a word every cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    hsv2rgb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_word  (i_hsv),
        .o_valid (w_prep_valid),
        .o_prep  (w_prep)
    );

    hsv2rgb_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_valid),
        .i_prep  (w_prep),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    hsv2rgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .o_valid (o_valid),
        .o_word  (o_rgb)
    );

    // every accepted word comes out as a result at o_valid
    `ASSERT_DELAYED(a_latency, i_clk, i_rst_n, w_accept, 4, o_valid, "result missing")
    // no result without an accepted word behind it
    `ASSERT_IMPLIES(a_no_extra, i_clk, i_rst_n, o_valid, $past(w_accept, 4), "spurious result")
    // a range error carries zero colour
    `ASSERT_IMPLIES(a_err_black, i_clk, i_rst_n, o_valid && o_rgb.range_error,
        (o_rgb.red == 8'd0) && (o_rgb.green == 8'd0) && (o_rgb.blue == 8'd0),
        "range error with colour")

endmodule

// ===== sim/tb_top.sv =====
// testbench of the hsv to rgb converter: directed table, then random pixels
// depends on hsv2rgb_pkg and hsv_to_rgb_converter; all words checked against the directed table or a local predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM     = 2000;
    localparam int N_PHASES     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RESET_CYCLES = 12;

    // exact fixed-point scale: channel = floor(n * 255 / 600000)
    localparam longint unsigned CHAN_SCALE = 255;
    localparam longint unsigned FX_DENOM   = 600000;
    localparam int unsigned     HUE_WRAP   = 120;
    localparam int unsigned     HUE_SECTOR = 60;
    localparam int unsigned     V_UNIT     = 6000;

    // one row of the directed table; rgb is used only where known is set
    typedef struct packed {
        hsv2rgb_pkg::t_hsv_word hsv;
        logic                   known;
        hsv2rgb_pkg::t_rgb_word rgb;
    } t_dir_row;

    localparam int N_DIR = 24;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // primaries and secondaries at full saturation and value
        '{'{9'd0,   7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{'{9'd60,  7'd100, 7'd100}, 1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
        '{'{9'd120, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
        '{'{9'd180, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}},
        '{'{9'd240, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
        '{'{9'd300, 7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}},
        // hue of exactly 360 lands in the last sector with no secondary
        '{'{9'd360, 7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        // white and black
        '{'{9'd0,   7'd0,   7'd100}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{'{9'd200, 7'd100, 7'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
        '{'{9'd0,   7'd0,   7'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
        // out of range fields give the error flag and black
        '{'{9'd361, 7'd50,  7'd50},  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{'{9'd511, 7'd127, 7'd127}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{'{9'd0,   7'd101, 7'd50},  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{'{9'd0,   7'd127, 7'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{'{9'd0,   7'd50,  7'd101}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{'{9'd360, 7'd100, 7'd127}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        // mid-sector and near-boundary colors, checked by the predictor
        '{'{9'd359, 7'd100, 7'd100}, 1'b0, '0},
        '{'{9'd30,  7'd50,  7'd50},  1'b0, '0},
        '{'{9'd90,  7'd100, 7'd50},  1'b0, '0},
        '{'{9'd119, 7'd1,   7'd1},   1'b0, '0},
        '{'{9'd1,   7'd99,  7'd99},  1'b0, '0},
        '{'{9'd210, 7'd73,  7'd88},  1'b0, '0},
        '{'{9'd359, 7'd1,   7'd100}, 1'b0, '0},
        '{'{9'd270, 7'd100, 7'd1},   1'b0, '0}
    };

    // sender idle percentage per phase
    localparam int IDLE_PCT [N_PHASES] = '{0, 72, 0, 32};

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start   = 1'b0;
    hsv2rgb_pkg::t_hsv_word i_hsv   = '0;
    logic                   busy;
    logic                   o_valid;
    hsv2rgb_pkg::t_rgb_word o_rgb;

    hsv2rgb_pkg::t_rgb_word pending_rgb [$];
    int        mismatch_cnt   = 0;
    int        word_cnt       = 0;
    int        error_flag_cnt = 0;
    int        cycle_cnt      = 0;
    int        idle_pct       = 0;

    hsv_to_rgb_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_hsv   (i_hsv),
        .o_valid (o_valid),
        .o_rgb   (o_rgb)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, pending_rgb.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // floor of a 1/600000 quantity scaled to 255
    function automatic logic [7:0] scale_channel(input int unsigned level);
        longint unsigned prod;
        prod = longint'(level) * CHAN_SCALE / FX_DENOM;
        return prod[7:0];
    endfunction

    // expected rgb word for one hsv word
    function automatic hsv2rgb_pkg::t_rgb_word predict_rgb(input hsv2rgb_pkg::t_hsv_word w);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned chroma;
        int unsigned second;
        int unsigned offs;
        int unsigned rem;
        int unsigned hue_dist;
        int unsigned lvl_r;
        int unsigned lvl_g;
        int unsigned lvl_b;
        hsv2rgb_pkg::t_sector   sec;
        hsv2rgb_pkg::t_rgb_word res;
        res = '0;
        h = w.hue;
        s = w.saturation;
        v = w.brightness;
        if (h > hsv2rgb_pkg::HUE_MAX || s > hsv2rgb_pkg::PCT_MAX
                || v > hsv2rgb_pkg::PCT_MAX) begin
            res.range_error = 1'b1;
            return res;
        end
        chroma   = s * v * HUE_SECTOR;
        rem      = h % HUE_WRAP;
        hue_dist = (rem >= HUE_SECTOR) ? (rem - HUE_SECTOR) : (HUE_SECTOR - rem);
        second   = s * v * (HUE_SECTOR - hue_dist);
        offs     = v * V_UNIT - chroma;
        sec      = (h == hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::SECTOR_MAG_RED
                                               : hsv2rgb_pkg::t_sector'(h / HUE_SECTOR);
        case (sec)
            hsv2rgb_pkg::SECTOR_RED_YEL: begin
                lvl_r = chroma; lvl_g = second; lvl_b = 0;
            end
            hsv2rgb_pkg::SECTOR_YEL_GRN: begin
                lvl_r = second; lvl_g = chroma; lvl_b = 0;
            end
            hsv2rgb_pkg::SECTOR_GRN_CYN: begin
                lvl_r = 0;      lvl_g = chroma; lvl_b = second;
            end
            hsv2rgb_pkg::SECTOR_CYN_BLU: begin
                lvl_r = 0;      lvl_g = second; lvl_b = chroma;
            end
            hsv2rgb_pkg::SECTOR_BLU_MAG: begin
                lvl_r = second; lvl_g = 0;      lvl_b = chroma;
            end
            default: begin
                lvl_r = chroma; lvl_g = 0;      lvl_b = second;
            end
        endcase
        res.red   = scale_channel(lvl_r + offs);
        res.green = scale_channel(lvl_g + offs);
        res.blue  = scale_channel(lvl_b + offs);
        return res;
    endfunction

    // random pixel: mostly valid, some sector edges, some raw noise
    function automatic hsv2rgb_pkg::t_hsv_word random_hsv();
        hsv2rgb_pkg::t_hsv_word w;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            w = $bits(hsv2rgb_pkg::t_hsv_word)'($urandom);
        end else begin
            w.saturation = 7'($urandom_range(100));
            w.brightness = 7'($urandom_range(100));
            if (pick < 25)
                w.hue = 9'(HUE_SECTOR * $urandom_range(6));
            else
                w.hue = 9'($urandom_range(360));
            if (pick >= 90) begin
                w.saturation = ($urandom_range(1)) ? hsv2rgb_pkg::PCT_MAX : 7'd0;
                w.brightness = ($urandom_range(1)) ? hsv2rgb_pkg::PCT_MAX
                                                   : 7'($urandom_range(1));
            end
        end
        return w;
    endfunction

    // present one word, with random idle cycles first, and log its expectation
    task automatic send_word(input hsv2rgb_pkg::t_hsv_word w, input logic known,
                             input hsv2rgb_pkg::t_rgb_word typed);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_hsv <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_rgb.insert(pending_rgb.size(), known ? typed : predict_rgb(w));
    endtask

    // result checker
    always @(posedge i_clk) begin
        hsv2rgb_pkg::t_rgb_word want;
        if (i_rst_n && o_valid === 1'b1) begin
            word_cnt <= word_cnt + 1;
            if (o_rgb.range_error === 1'b1)
                error_flag_cnt <= error_flag_cnt + 1;
            if (pending_rgb.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected word at cycle %0d: r=%0d g=%0d b=%0d err=%b",
                             cycle_cnt, o_rgb.red, o_rgb.green, o_rgb.blue,
                             o_rgb.range_error);
            end else begin
                want = pending_rgb.pop_front();
                if (o_rgb.red !== want.red || o_rgb.green !== want.green ||
                    o_rgb.blue !== want.blue || o_rgb.range_error !== want.range_error) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch at cycle %0d: exp %0d/%0d/%0d/%b got %0d/%0d/%0d/%b",
                                 cycle_cnt, want.red, want.green, want.blue, want.range_error,
                                 o_rgb.red, o_rgb.green, o_rgb.blue, o_rgb.range_error);
                end
            end
        end
    end

    // stimulus
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
            send_word(DIR_ROWS[i].hsv, DIR_ROWS[i].known, DIR_ROWS[i].rgb);

        // random pixels over the idle phases
        for (int p = 0; p < N_PHASES; p++) begin
            idle_pct = IDLE_PCT[p];
            for (int i = 0; i < N_RANDOM / N_PHASES; i++)
                send_word(random_hsv(), 1'b0, '0);
        end
        start <= 1'b0;

        // drain
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d directed and %0d random pixels over %0d idle phases",
                 N_DIR, N_RANDOM, N_PHASES);
        $display("%0d words checked, %0d with range error, %0d mismatches",
                 word_cnt, error_flag_cnt, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
